// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TSBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tsbc_pkg.sv
// types, constants and register map of the station-stop brake controller
package tsbc_pkg;

    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int RAD_W         = 40;
    localparam int LIM_W         = 12;
    localparam int SQRT_BITS_DEF = 32;

    localparam logic [2:0] REG_DECEL     = 3'd0;
    localparam logic [2:0] REG_SPEED_CAP = 3'd1;
    localparam logic [2:0] REG_DOOR      = 3'd2;
    localparam logic [2:0] REG_EMERG     = 3'd3;
    localparam logic [2:0] REG_MAX_SVC   = 3'd4;

    localparam logic [7:0]  RST_DECEL     = 8'd16;
    localparam logic [11:0] RST_SPEED_CAP = 12'd1600;
    localparam logic [11:0] RST_DOOR      = 12'd16;
    localparam logic [4:0]  RST_EMERG     = 5'd9;
    localparam logic [4:0]  RST_MAX_SVC   = 5'd8;

    // 0.85 as 871/1024
    localparam logic [9:0] LIM_GAIN = 10'd871;

    // x / 1000 as (x * ceil(2^30 / 1000)) >> 30, exact for 20-bit x
    localparam logic [20:0] MOD_RECIP = 21'd1073742;
    localparam int          MOD_SHIFT = 30;
    localparam logic [9:0]  MOD_DIV   = 10'd1000;

    localparam logic signed [12:0] NEAR_SPEED  = 13'sd80;
    localparam logic signed [12:0] CREEP_SPEED = 13'sd24;
    localparam logic [4:0]         HOLD_NOTCH  = 5'd4;

    typedef enum logic [1:0] {
        K_TICK,
        K_BEACON,
        K_EMERGENCY,
        K_CANCEL
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_ROOT,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [7:0]  decel;
        logic [11:0] speed_cap;
        logic [11:0] stop_extra;
        logic [4:0]  emergency_notch;
        logic [4:0]  max_service_notch;
    } t_cfg;

    typedef struct packed {
        logic [4:0] notch;
        logic       armed;
        logic       active;
        logic       hold;
    } t_flags;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] position;
        logic signed [12:0] speed;
        logic [4:0]         manual_brake;
        logic               stop_enabled;
        logic signed [3:0]  beacon_index;
        logic [19:0]        beacon_data;
        logic [2:0]         coin_bits;
    } t_item;

endpackage

// File: rtl/tsbc_if.sv
// input and result channel interfaces
interface tsbc_in_if;
    logic               valid;
    logic               ready;
    tsbc_pkg::t_kind    kind;
    logic signed [31:0] position;
    logic signed [12:0] speed;
    logic [4:0]         manual_brake;
    logic               stop_enabled;
    logic signed [3:0]  beacon_index;
    logic [19:0]        beacon_data;
    logic [2:0]         coin_bits;

    modport source (
        output valid, kind, position, speed, manual_brake, stop_enabled,
               beacon_index, beacon_data, coin_bits,
        input  ready
    );
    modport sink (
        input  valid, kind, position, speed, manual_brake, stop_enabled,
               beacon_index, beacon_data, coin_bits,
        output ready
    );
endinterface

interface tsbc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] brake_notch;
    logic       control_armed;
    logic       braking_active;
    logic       stop_hold;

    modport source (
        output valid, brake_notch, control_armed, braking_active, stop_hold,
        input  ready
    );
    modport sink (
        input  valid, brake_notch, control_armed, braking_active, stop_hold,
        output ready
    );
endinterface

// File: rtl/tsbc_apb_regs.sv
// apb configuration registers
module tsbc_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsbc_pkg::ADDR_W-1:0] paddr,
    input  logic [tsbc_pkg::DATA_W-1:0] pwdata,
    output logic [tsbc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tsbc_pkg::t_cfg              o_cfg
);
    import tsbc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decel             <= RST_DECEL;
            r_cfg.speed_cap         <= RST_SPEED_CAP;
            r_cfg.stop_extra        <= RST_DOOR;
            r_cfg.emergency_notch   <= RST_EMERG;
            r_cfg.max_service_notch <= RST_MAX_SVC;
        end else if (w_wr) begin
            case (w_idx)
                REG_DECEL:     r_cfg.decel             <= pwdata[7:0];
                REG_SPEED_CAP: r_cfg.speed_cap         <= pwdata[11:0];
                REG_DOOR:      r_cfg.stop_extra        <= pwdata[11:0];
                REG_EMERG:     r_cfg.emergency_notch   <= pwdata[4:0];
                REG_MAX_SVC:   r_cfg.max_service_notch <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DECEL:     prdata = DATA_W'(r_cfg.decel);
            REG_SPEED_CAP: prdata = DATA_W'(r_cfg.speed_cap);
            REG_DOOR:      prdata = DATA_W'(r_cfg.stop_extra);
            REG_EMERG:     prdata = DATA_W'(r_cfg.emergency_notch);
            REG_MAX_SVC:   prdata = DATA_W'(r_cfg.max_service_notch);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/tsbc_isqrt.sv
// iterative integer square root, one result bit per cycle
module tsbc_isqrt #(
    parameter int SQRT_BITS = tsbc_pkg::SQRT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tsbc_pkg::RAD_W-1:0] i_radicand,
    output logic                       o_last,
    output logic [SQRT_BITS-1:0]       o_root
);
    import tsbc_pkg::*;

    localparam int RW    = 2 * SQRT_BITS;
    localparam int REM_W = SQRT_BITS + 2;
    localparam int CNT_W = $clog2(SQRT_BITS + 1);

    logic [RW-1:0]        r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [SQRT_BITS-1:0] r_root;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_cnt;

    logic [RW-1:0]    w_rad_in;
    logic             w_ovf_in;
    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    // fit the radicand; anything beyond 2*SQRT_BITS bits saturates the root
    generate
        if (RW > RAD_W) begin : g_wide
            assign w_rad_in = {{(RW - RAD_W){1'b0}}, i_radicand};
            assign w_ovf_in = 1'b0;
        end else if (RW == RAD_W) begin : g_equal
            assign w_rad_in = i_radicand;
            assign w_ovf_in = 1'b0;
        end else begin : g_narrow
            assign w_rad_in = i_radicand[RW-1:0];
            assign w_ovf_in = |i_radicand[RAD_W-1:RW];
        end
    endgenerate

    assign w_rem_sh = {r_rem[SQRT_BITS-1:0], r_rad[RW-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign o_last   = (r_cnt == CNT_W'(1));
    assign o_root   = r_ovf ? '1 : r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SQRT_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= w_rad_in;
            r_rem  <= '0;
            r_root <= '0;
            r_ovf  <= w_ovf_in;
        end else if (r_cnt != '0) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[SQRT_BITS-2:0], w_ge};
        end
    end

endmodule

// File: rtl/tsbc_notch_step.sv
// notch stepping, standstill hold and clamp for one tick
module tsbc_notch_step (
    input  tsbc_pkg::t_flags            i_flags,
    input  tsbc_pkg::t_cfg              i_cfg,
    input  logic [tsbc_pkg::LIM_W-1:0]  i_lim,
    input  logic signed [12:0]          i_speed,
    input  logic [4:0]                  i_manual,
    input  logic                        i_enabled,
    input  logic [2:0]                  i_coins,
    output tsbc_pkg::t_flags            o_flags
);
    import tsbc_pkg::*;

    function automatic logic coin_at(input logic [2:0] bits, input logic [1:0] pos);
        coin_at = (pos == 2'd3) ? 1'b0 : bits[pos];
    endfunction

    logic [21:0]        w_lim_mul;
    logic               w_brake;
    logic               w_lim_gt;
    logic               w_lim_lt;
    logic               w_near;
    logic               w_creep;
    logic               w_still;
    logic signed [6:0]  w_half;
    logic signed [13:0] w_lim_s;
    logic signed [13:0] w_spd_s;

    logic signed [6:0] n;
    logic [1:0]        cp;
    logic              coin;
    t_flags            f;

    assign w_lim_mul = 22'(i_lim) * 22'(LIM_GAIN);
    assign w_brake   = $signed({2'b00, w_lim_mul}) < $signed({i_speed[12], i_speed, 10'b0});
    assign w_lim_s   = $signed({2'b00, i_lim});
    assign w_spd_s   = $signed({i_speed[12], i_speed});
    assign w_lim_gt  = (w_lim_s > w_spd_s);
    assign w_lim_lt  = (w_lim_s < w_spd_s);
    assign w_near    = (i_speed > -NEAR_SPEED) && (i_speed < NEAR_SPEED);
    assign w_creep   = (i_speed > -CREEP_SPEED) && (i_speed < CREEP_SPEED);
    assign w_still   = (i_speed == 13'sd0);
    assign w_half    = $signed({3'b000, i_cfg.emergency_notch[4:1]});

    always_comb begin
        n    = $signed({2'b00, i_flags.notch});
        f    = i_flags;
        cp   = 2'd0;
        coin = 1'b0;
        if (i_enabled) begin
            if (f.armed) begin
                if (w_brake) begin
                    f.active = 1'b1;
                    if (w_lim_gt) begin
                        n = n + 7'sd1;
                    end else if (w_lim_lt) begin
                        coin = coin_at(i_coins, cp);
                        cp   = cp + 2'd1;
                        if (coin) n = n - 7'sd1;
                    end
                end else begin
                    coin = coin_at(i_coins, cp);
                    cp   = cp + 2'd1;
                    if (coin) n = n - 7'sd1;
                end
                if (w_near) begin
                    if (n > w_half) begin
                        coin = coin_at(i_coins, cp);
                        cp   = cp + 2'd1;
                        if (coin) n = n - 7'sd1;
                    end else if (n < w_half) begin
                        coin = coin_at(i_coins, cp);
                        cp   = cp + 2'd1;
                        if (coin) n = n + 7'sd1;
                    end
                    if (w_creep && n > 7'sd1) begin
                        coin = coin_at(i_coins, cp);
                        if (coin) n = n - 7'sd1;
                    end
                    if (w_still) f.hold = 1'b1;
                end
            end
            if (f.hold) begin
                f.armed  = 1'b0;
                f.active = 1'b0;
                n        = $signed({2'b00, HOLD_NOTCH});
                if (i_manual > HOLD_NOTCH) begin
                    n      = 7'sd0;
                    f.hold = 1'b0;
                end
            end
        end
        // clamp
        if (n < 7'sd0) begin
            n = 7'sd0;
        end else if (n >= $signed({2'b00, i_cfg.emergency_notch})) begin
            n = $signed({2'b00, i_cfg.max_service_notch});
        end
        f.notch = n[4:0];
    end

    assign o_flags = f;

endmodule

// File: rtl/train_stop_brake_controller_unit.sv
// top level of the station-stop brake controller
// path: a tick that needs the limit root goes through S_PREP, S_ROOT and S_APPLY, the root
//   unit taking one result bit per cycle; every other item goes from S_PREP to S_APPLY
// throughput: one item at a time, the next accepted once the result is registered
// a stalled result holds the block before it updates state, but the input stays open in idle
// reset (synchronous): flags, notch and stop location cleared, registers to defaults
module train_stop_brake_controller_unit #(
    parameter int SQRT_BITS = tsbc_pkg::SQRT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tsbc_in_if.sink                     i_item,
    tsbc_out_if.source                  o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsbc_pkg::ADDR_W-1:0] paddr,
    input  logic [tsbc_pkg::DATA_W-1:0] pwdata,
    output logic [tsbc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tsbc_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_item       r_item;
    t_flags      r_flags;
    logic [31:0] r_stop;
    logic        r_out_valid;
    logic        r_neg;
    logic [10:0] r_quot;

    t_cfg                 w_cfg;
    t_flags               w_tick_flags;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_need_root;
    logic                 w_start;
    logic                 w_commit;
    logic                 w_last;
    logic [SQRT_BITS-1:0] w_root;
    logic [LIM_W-1:0]     w_lim;
    logic signed [32:0]   w_dist;
    logic [RAD_W-1:0]     w_radicand;
    logic [40:0]          w_prod;
    logic [19:0]          w_rem;
    logic [31:0]          w_stop_new;
    logic                 w_slot_ok;

    tsbc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_dist      = $signed({r_stop[31], r_stop})
                       - $signed({r_item.position[31], r_item.position});
    assign w_radicand  = RAD_W'(w_dist[31:0]) * RAD_W'(w_cfg.decel);
    assign w_need_root = (r_item.kind == K_TICK) && r_item.stop_enabled
                       && r_flags.armed && !w_dist[32];

    tsbc_isqrt #(
        .SQRT_BITS (SQRT_BITS)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_radicand (w_radicand),
        .o_last     (w_last),
        .o_root     (w_root)
    );

    assign w_lim = (r_neg || (w_root >= SQRT_BITS'(w_cfg.speed_cap)))
                 ? w_cfg.speed_cap : w_root[LIM_W-1:0];

    tsbc_notch_step u_step (
        .i_flags   (r_flags),
        .i_cfg     (w_cfg),
        .i_lim     (w_lim),
        .i_speed   (r_item.speed),
        .i_manual  (r_item.manual_brake),
        .i_enabled (r_item.stop_enabled),
        .i_coins   (r_item.coin_bits),
        .o_flags   (w_tick_flags)
    );

    // beacon distance: data mod 1000 through the reciprocal
    assign w_prod     = 41'(r_item.beacon_data) * 41'(MOD_RECIP);
    assign w_rem      = r_item.beacon_data - 20'(20'(r_quot) * 20'(MOD_DIV));
    assign w_stop_new = 32'(r_item.position) + 32'({w_rem[9:0], 4'b0000})
                      + 32'(w_cfg.stop_extra);
    assign w_slot_ok  = !r_item.beacon_index[3] && (r_item.beacon_index[2:0] <= 3'd4);

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state      = r_state;
        w_start      = 1'b0;
        w_commit     = 1'b0;
        i_item.ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_item.ready = 1'b1;
                if (w_accept) n_state = S_PREP;
            end
            S_PREP: begin
                if (w_need_root) begin
                    w_start = 1'b1;
                    n_state = S_ROOT;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_ROOT: begin
                if (w_last) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_stop  <= '0;
        end else if (w_commit) begin
            case (r_item.kind)
                K_TICK: begin
                    r_flags <= w_tick_flags;
                end
                K_BEACON: begin
                    if (w_slot_ok) begin
                        r_flags.armed <= 1'b1;
                        r_stop        <= w_stop_new;
                    end
                end
                K_EMERGENCY: begin
                    r_flags <= '0;
                end
                K_CANCEL: begin
                    r_flags.armed  <= 1'b0;
                    r_flags.active <= 1'b0;
                    r_stop         <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.kind         <= i_item.kind;
            r_item.position     <= i_item.position;
            r_item.speed        <= i_item.speed;
            r_item.manual_brake <= i_item.manual_brake;
            r_item.stop_enabled <= i_item.stop_enabled;
            r_item.beacon_index <= i_item.beacon_index;
            r_item.beacon_data  <= i_item.beacon_data;
            r_item.coin_bits    <= i_item.coin_bits;
        end
        if (r_state == S_PREP) begin
            r_neg  <= w_dist[32];
            r_quot <= w_prod[MOD_SHIFT +: 11];
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.brake_notch    = r_flags.notch;
    assign o_result.control_armed  = r_flags.armed;
    assign o_result.braking_active = r_flags.active;
    assign o_result.stop_hold      = r_flags.hold;

endmodule

// File: rtl/tsbc_checker.sv
// port-level checker for the brake controller and its bind
`include "assert_macros.svh"

module tsbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_payload
);

    `TSBC_ASSERT_NXT(a_out_valid_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    `TSBC_ASSERT_NXT(a_out_payload_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_payload), "result changed while stalled")

    `TSBC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "second transaction taken while busy")

    `TSBC_ASSERT_NXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid), "result appeared before processing")

    `TSBC_ASSERT_IMP(a_idle_on_result, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready, "not idle after result registered")

endmodule

bind train_stop_brake_controller_unit tsbc_checker u_tsbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload ({o_result.brake_notch, o_result.control_armed,
                     o_result.braking_active, o_result.stop_hold})
);
